>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the image header sniffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define IHSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define IHSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ihss_pkg.sv
// Package: constants, format codes and helpers of the image header sniffer.
package ihss_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int HEADER_LEN        = 24;
	localparam int WIN_LEN           = 12;
	localparam int FIRST_WINDOW_END  = 13;
	localparam int DIM_BITS          = 32;

	// Result format codes
	localparam logic [1:0] FMT_NONE = 2'd0;
	localparam logic [1:0] FMT_JPEG = 2'd1;
	localparam logic [1:0] FMT_GIF  = 2'd2;
	localparam logic [1:0] FMT_PNG  = 2'd3;

	// JPEG markers
	localparam logic [7:0] MRK_PREFIX = 8'hFF;
	localparam logic [7:0] MRK_SOI    = 8'hD8;
	localparam logic [7:0] MRK_APP0   = 8'hE0;

	typedef logic [7:0] byte_t;

	function automatic logic is_frame_marker(input byte_t m);
		logic r;
		case (m) inside
			8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/image_header_size_sniffer.sv
// Top level: byte-stream sniffer for JPEG/GIF/PNG image dimensions.
// The final byte (tlast) passes the byte register; its result word is then registered.
// Throughput: one byte word per cycle; only a final byte stalls, and only while the
// previous result word still sits untaken in the output register.
// Reset (arst_n low, asynchronous): pipeline and result empty, position zero,
// first window end at byte 13; after each result the same state is restored.
`include "assert_macros.svh"

module image_header_size_sniffer
	import ihss_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] width, [63:32] height
	output logic [2:0]  m_tuser    // [0] found, [2:1] image_format
);

	localparam int PB = POSITION_BITS;
	localparam int EB = POSITION_BITS + 1;

	localparam logic [PB-1:0] POS_MAX   = {PB{1'b1}};
	localparam logic [EB-1:0] END_MAX   = {EB{1'b1}};
	localparam logic [EB-1:0] END_FIRST = EB'(FIRST_WINDOW_END);

	// ---------------- stage 1: byte register ----------------
	logic  valid_s1;
	byte_t data_s1;
	logic  eof_s1;
	logic  advance;

	// A non-final byte never produces a word, so it always moves on; the final
	// byte waits only while an untaken result still sits in the output register.
	assign advance  = valid_s1 && (!eof_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	// ---------------- stage 2: sniffer state ----------------
	byte_t           hdr_q [HEADER_LEN];   // first 24 bytes of the file
	byte_t           win_q [WIN_LEN];      // last 12 bytes, oldest at 0
	logic [PB-1:0]   pos_q;                // index of the next byte
	logic [EB-1:0]   wep_q;                // last byte index of next window
	logic            scan_q;               // walking the JFIF segment chain
	byte_t           lead_q;               // lead byte of the window in force
	logic [31:0]     dims_q;               // bytes 5..8 of the window in force

	logic            tracked;
	logic            hit;
	logic            first_win;
	logic            jfif;
	logic            scan_pre;
	logic            scan_n;
	logic [EB-1:0]   wep_n;
	byte_t           lead_n;
	logic [31:0]     dims_n;
	logic [EB:0]     wep_sum;
	logic [PB-1:0]   pos_n;

	assign tracked   = pos_q != POS_MAX;
	assign hit       = tracked && ({1'b0, pos_q} == wep_q);
	assign first_win = pos_q == PB'(FIRST_WINDOW_END);

	// JFIF check: FF D8 FF E0 .. .. 'J' 'F' 'I' 'F'
	assign jfif = hdr_q[0] == MRK_PREFIX && hdr_q[1] == MRK_SOI &&
	              hdr_q[2] == MRK_PREFIX && hdr_q[3] == MRK_APP0 &&
	              hdr_q[6] == 8'h4A && hdr_q[7] == 8'h46 &&
	              hdr_q[8] == 8'h49 && hdr_q[9] == 8'h46;

	// Window completing this cycle is win_q[1..11] plus the incoming byte, so
	// window byte k sits in win_q[k+1].
	assign wep_sum = {1'b0, wep_q} + (EB+1)'(2) + (EB+1)'({win_q[3], win_q[4]});

	always_comb begin
		scan_pre = (hit && first_win) ? jfif : scan_q;
		scan_n   = scan_pre;
		wep_n    = wep_q;
		lead_n   = lead_q;
		dims_n   = dims_q;
		if (hit && (first_win || scan_pre)) begin
			lead_n = win_q[1];
			dims_n = {win_q[6], win_q[7], win_q[8], win_q[9]};
		end
		if (hit && scan_pre) begin
			if (win_q[1] != MRK_PREFIX || is_frame_marker(win_q[2])) begin
				scan_n = 1'b0;
			end else begin
				wep_n = wep_sum[EB] ? END_MAX : wep_sum[EB-1:0];
			end
		end
		pos_n = tracked ? pos_q + PB'(1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			wep_q  <= END_FIRST;
			scan_q <= 1'b0;
			lead_q <= '0;
			dims_q <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				pos_q  <= '0;
				wep_q  <= END_FIRST;
				scan_q <= 1'b0;
				lead_q <= '0;
				dims_q <= '0;
			end else begin
				pos_q  <= pos_n;
				wep_q  <= wep_n;
				scan_q <= scan_n;
				lead_q <= lead_n;
				dims_q <= dims_n;
			end
		end
	end

	// Header bytes and window: every entry that is ever read has been written
	// earlier in the same file, so they need no clearing.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < HEADER_LEN; i++) begin
				if (pos_q == PB'(i)) begin
					hdr_q[i] <= data_s1;
				end
			end
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_LEN-1] <= data_s1;
		end
	end

	// ---------------- result decode ----------------
	byte_t       h23;
	logic        long_enough;
	logic        is_jpeg;
	logic        is_gif;
	logic        is_png;
	logic [1:0]  fmt;
	logic [31:0] wid;
	logic [31:0] hgt;

	// The last header byte may arrive together with the final byte.
	assign h23         = (pos_q == PB'(HEADER_LEN - 1)) ? data_s1 : hdr_q[HEADER_LEN-1];
	assign long_enough = pos_q >= PB'(HEADER_LEN - 1);

	assign is_jpeg = hdr_q[0] == MRK_PREFIX && hdr_q[1] == MRK_SOI && lead_n == MRK_PREFIX;
	assign is_gif  = hdr_q[0] == 8'h47 && hdr_q[1] == 8'h49 && hdr_q[2] == 8'h46;
	// PNG signature 89 'PNG' 0D 0A 1A 0A, then chunk type 'IHDR'
	assign is_png  = hdr_q[0] == 8'h89 && hdr_q[1] == 8'h50 && hdr_q[2] == 8'h4E &&
	                 hdr_q[3] == 8'h47 && hdr_q[4] == 8'h0D && hdr_q[5] == 8'h0A &&
	                 hdr_q[6] == 8'h1A && hdr_q[7] == 8'h0A && hdr_q[12] == 8'h49 &&
	                 hdr_q[13] == 8'h48 && hdr_q[14] == 8'h44 && hdr_q[15] == 8'h52;

	always_comb begin
		fmt = FMT_NONE;
		wid = '0;
		hgt = '0;
		if (long_enough) begin
			if (is_jpeg) begin
				fmt = FMT_JPEG;
				hgt = {16'h0, dims_n[31:16]};
				wid = {16'h0, dims_n[15:0]};
			end else if (is_gif) begin
				fmt = FMT_GIF;
				wid = {16'h0, hdr_q[7], hdr_q[6]};
				hgt = {16'h0, hdr_q[9], hdr_q[8]};
			end else if (is_png) begin
				fmt = FMT_PNG;
				wid = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19]};
				hgt = {hdr_q[20], hdr_q[21], hdr_q[22], h23};
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && eof_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eof_s1) begin
			m_tdata <= {hgt, wid};
			m_tuser <= {fmt, fmt != FMT_NONE};
		end
	end

	// ---------------- assertions ----------------
	`IHSS_ASSERT(a_wep_floor, wep_q >= END_FIRST, "window end below first window")
	`IHSS_ASSERT(a_scan_pos, !scan_q || pos_q > PB'(FIRST_WINDOW_END),
		"segment walk active before first window")
	`IHSS_ASSERT(a_found_fmt, !m_tvalid || (m_tuser[0] == (m_tuser[2:1] != FMT_NONE)),
		"found flag disagrees with format")
	`IHSS_ASSERT(a_fail_zero, !m_tvalid || m_tuser[0] || m_tdata == '0,
		"failed result carries nonzero dimensions")
	`IHSS_ASSERT_NEXT(a_eof_rearm, advance && eof_s1,
		pos_q == '0 && wep_q == END_FIRST && !scan_q && m_tvalid,
		"state not restored after final byte")

endmodule

>>> tb/ihss_scoreboard_pkg.sv
// Scoreboard package: byte-level dimension predictor and result checker for the sniffer.
package ihss_scoreboard_pkg;
	import ihss_pkg::*;

	localparam longint unsigned POS_SAT   = (64'd1 << POSITION_BITS_DEF) - 1;
	localparam longint unsigned END_SAT   = (64'd1 << (POSITION_BITS_DEF + 1)) - 1;
	localparam logic [63:0]     PNG_MAGIC = 64'h89504E470D0A1A0A;

	typedef struct packed {
		logic        found;
		logic [1:0]  image_format;
		logic [31:0] width;
		logic [31:0] height;
	} dims_t;

	class sniff_scoreboard;
		byte_t           hdr[HEADER_LEN];
		byte_t           win[WIN_LEN];
		longint unsigned pos;
		longint unsigned win_end;
		bit              walking;
		byte_t           lead;
		logic [31:0]     frame_dims;
		dims_t           dims_q[$];
		int              mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (hdr[i]) hdr[i] = '0;
			foreach (win[i]) win[i] = '0;
			pos        = 0;
			win_end    = FIRST_WINDOW_END;
			walking    = 1'b0;
			lead       = '0;
			frame_dims = '0;
		endfunction

		function bit sof_marker(byte_t m);
			return m inside {8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB};
		endfunction

		function bit jfif_start();
			return hdr[0] == MRK_PREFIX && hdr[1] == MRK_SOI && hdr[2] == MRK_PREFIX &&
				hdr[3] == MRK_APP0 && {hdr[6], hdr[7], hdr[8], hdr[9]} == "JFIF";
		endfunction

		// Accepted byte word: advance the predictor, queue a result on end of file.
		function void note_byte(byte_t b, logic last);
			longint unsigned idx;
			longint unsigned nxt;
			bit              tracked;
			dims_t           r;
			idx     = pos;
			tracked = idx < POS_SAT;
			if (tracked && idx < HEADER_LEN) hdr[idx] = b;
			for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
			win[WIN_LEN - 1] = b;

			if (tracked && idx == win_end) begin
				if (idx == FIRST_WINDOW_END) walking = jfif_start();
				if (idx == FIRST_WINDOW_END || walking) begin
					lead       = win[0];
					frame_dims = {win[5], win[6], win[7], win[8]};
				end
				if (walking) begin
					if (win[0] != MRK_PREFIX || sof_marker(win[1])) begin
						walking = 1'b0;
					end else begin
						nxt     = win_end + 2 + {win[2], win[3]};
						win_end = (nxt > END_SAT) ? END_SAT : nxt;
					end
				end
			end
			if (tracked) pos = idx + 1;
			if (!last) return;

			r = '0;
			if (idx >= HEADER_LEN - 1) begin
				if (hdr[0] == MRK_PREFIX && hdr[1] == MRK_SOI && lead == MRK_PREFIX) begin
					r.image_format = FMT_JPEG;
					r.height       = frame_dims[31:16];
					r.width        = frame_dims[15:0];
				end else if ({hdr[0], hdr[1], hdr[2]} == "GIF") begin
					r.image_format = FMT_GIF;
					r.width        = {hdr[7], hdr[6]};
					r.height       = {hdr[9], hdr[8]};
				end else if ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]}
						== PNG_MAGIC && {hdr[12], hdr[13], hdr[14], hdr[15]} == "IHDR") begin
					r.image_format = FMT_PNG;
					r.width        = {hdr[16], hdr[17], hdr[18], hdr[19]};
					r.height       = {hdr[20], hdr[21], hdr[22], hdr[23]};
				end
			end
			r.found = (r.image_format != FMT_NONE);
			dims_q.push_back(r);
			restart();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
		endfunction

		// Accepted result word: compare against the oldest queued result.
		function void check_result(logic [2:0] user, logic [63:0] data);
			dims_t got;
			dims_t want;
			got = {user[0], user[2:1], data[31:0], data[63:32]};
			if (dims_q.size() == 0) begin
				flag($sformatf("result word with nothing queued: found %0d fmt %0d w %h h %h",
					got.found, got.image_format, got.width, got.height));
				return;
			end
			want = dims_q.pop_front();
			if (got.found !== want.found)
				flag($sformatf("found: expected %0d, got %0d", want.found, got.found));
			if (got.image_format !== want.image_format)
				flag($sformatf("format: expected %0d, got %0d",
					want.image_format, got.image_format));
			if (got.width !== want.width)
				flag($sformatf("width: expected %h, got %h", want.width, got.width));
			if (got.height !== want.height)
				flag($sformatf("height: expected %h, got %h", want.height, got.height));
		endfunction

		function int pending();
			return dims_q.size();
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
// Testbench top: drives image files byte by byte into the sniffer and checks every result word.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ihss_pkg::*;
	import ihss_scoreboard_pkg::*;

	localparam int    HOLD_CYCLES  = 300;     // long receiver hold-off for back-pressure
	localparam int    RANDOM_WORDS = 900;
	localparam int    MIN_FILES    = 12;
	localparam byte_t SOF_CODES[7] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC9, 8'hCA, 8'hCB};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;   // [31:0] width, [63:32] height
	logic [2:0]  m_tuser;   // [0] found, [2:1] image_format

	sniff_scoreboard sb = new();

	int send_idle_pct = 0;   // chance per word that the sender idles first, drawn again after each idle cycle
	int recv_idle_pct = 0;   // chance per cycle that the receiver drops tready
	bit hold_req      = 1'b0;
	int words_sent    = 0;

	image_header_size_sniffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---- file builders ----

	function automatic void push_text(ref byte_t f[$], input string s);
		foreach (s[i]) f.push_back(s[i]);
	endfunction

	function automatic void push_random(ref byte_t f[$], input int n);
		repeat (n) f.push_back(8'($urandom));
	endfunction

	// cut a file down to n bytes
	function automatic void chop(ref byte_t f[$], input int n);
		while (f.size() > n) void'(f.pop_back());
	endfunction

	// GIF: signature, little-endian width/height, padded to total bytes
	function automatic void build_gif(ref byte_t f[$], input logic [15:0] w,
			input logic [15:0] h, input int total);
		f.delete();
		push_text(f, ($urandom_range(1) != 0) ? "GIF89a" : "GIF87a");
		f.push_back(w[7:0]);
		f.push_back(w[15:8]);
		f.push_back(h[7:0]);
		f.push_back(h[15:8]);
		push_random(f, total - f.size());
	endfunction

	// PNG: magic, chunk length, IHDR, big-endian width/height, then tail bytes
	function automatic void build_png(ref byte_t f[$], input logic [31:0] w,
			input logic [31:0] h, input int tail);
		f.delete();
		for (int i = 7; i >= 0; i--) f.push_back(PNG_MAGIC[i*8 +: 8]);
		push_random(f, 4);
		push_text(f, "IHDR");
		for (int i = 3; i >= 0; i--) f.push_back(w[i*8 +: 8]);
		for (int i = 3; i >= 0; i--) f.push_back(h[i*8 +: 8]);
		push_random(f, tail);
	endfunction

	// JFIF: SOI, APP0, some filler segments, then a frame segment.
	// spoil picks a segment (after APP0) whose leading FF is replaced.
	function automatic void build_jfif(ref byte_t f[$], input int extras, input byte_t sof,
			input logic [15:0] w, input logic [15:0] h, input int tail, input int spoil);
		int seg_len;
		int marks[$];
		f.delete();
		f.push_back(MRK_PREFIX);
		f.push_back(MRK_SOI);
		seg_len = $urandom_range(7, 24);
		f.push_back(MRK_PREFIX);
		f.push_back(MRK_APP0);
		f.push_back(8'(seg_len >> 8));
		f.push_back(8'(seg_len));
		push_text(f, "JFIF");
		f.push_back(8'h00);
		push_random(f, seg_len - 7);
		repeat (extras) begin
			// D0..FE holds no frame marker
			seg_len = ($urandom_range(9) == 0) ? $urandom_range(2, 300) : $urandom_range(2, 30);
			marks.push_back(f.size());
			f.push_back(MRK_PREFIX);
			f.push_back(8'($urandom_range(8'hD0, 8'hFE)));
			f.push_back(8'(seg_len >> 8));
			f.push_back(8'(seg_len));
			push_random(f, seg_len - 2);
		end
		marks.push_back(f.size());
		f.push_back(MRK_PREFIX);
		f.push_back(sof);
		f.push_back(8'h00);
		f.push_back(8'h11);
		f.push_back(8'h08);
		f.push_back(h[15:8]);
		f.push_back(h[7:0]);
		f.push_back(w[15:8]);
		f.push_back(w[7:0]);
		push_random(f, 10);
		push_random(f, tail);
		if (spoil >= 0 && spoil < marks.size()) f[marks[spoil]] = 8'($urandom_range(0, 254));
	endfunction

	// ---- drivers ----

	task automatic send_word(input byte_t b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, last);
		words_sent++;
	endtask

	task automatic send_file(ref byte_t f[$]);
		foreach (f[i]) send_word(f[i], i == f.size() - 1);
	endtask

	// ---- result sink: random tready, plus one long hold-off on request ----
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ---- stimulus ----
	initial begin
		byte_t img[$];
		int    pick;
		int    n;
		int    base;
		int    files;
		int    extras;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-byte file, short files, field extremes, each kind of file
		img = '{8'hFF};
		send_file(img);
		build_gif(img, 16'h0001, 16'h0001, 30);
		chop(img, HEADER_LEN - 1);                     // one byte too short
		send_file(img);
		build_png(img, 32'hFFFF_FFFF, 32'h0000_0000, 0);  // exactly 24 bytes
		send_file(img);
		build_png(img, 32'h8000_0001, 32'hFFFF_FFFF, 3);
		send_file(img);
		build_gif(img, 16'hFFFF, 16'h0000, HEADER_LEN);
		send_file(img);
		build_jfif(img, 1, 8'hCB, 16'hFFFF, 16'h0001, 0, -1);
		send_file(img);
		build_jfif(img, 0, 8'hC0, 16'h0000, 16'hFFFF, 2, -1);
		send_file(img);
		build_jfif(img, 1, 8'hC2, 16'h1234, 16'h5678, 0, 1);  // frame lead not FF
		send_file(img);
		build_jfif(img, 0, 8'hC9, 16'h0100, 16'h0200, 0, -1);
		chop(img, img.size() - 10);                    // frame window never completes
		send_file(img);
		img = '{MRK_PREFIX, MRK_SOI, MRK_PREFIX, 8'hE1};  // FF D8 but not JFIF
		push_random(img, 22);
		send_file(img);
		img.delete();
		repeat (HEADER_LEN) img.push_back(8'h00);
		send_file(img);

		// back-pressure: receiver holds off while tiny files keep coming
		recv_idle_pct = 20;
		hold_req      = 1'b1;
		repeat (24) begin
			img.delete();
			push_random(img, $urandom_range(1, 3));
			send_file(img);
		end

		// random files, three idling phases
		base  = words_sent;
		files = 0;
		while (words_sent - base < RANDOM_WORDS || files < MIN_FILES) begin
			n = words_sent - base;
			if (n < RANDOM_WORDS / 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 53;
			end else if (n < 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 53;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(99);
			if (pick < 35) begin
				extras = $urandom_range(3);
				build_jfif(img, extras, SOF_CODES[$urandom_range(6)], 16'($urandom),
					16'($urandom), $urandom_range(6),
					($urandom_range(7) == 0) ? int'($urandom_range(extras)) : -1);
			end else if (pick < 55) begin
				build_gif(img, 16'($urandom), 16'($urandom), $urandom_range(HEADER_LEN, 40));
				if ($urandom_range(7) == 0) img[$urandom_range(2)] = 8'($urandom);
			end else if (pick < 75) begin
				build_png(img, $urandom, $urandom, $urandom_range(12));
				if ($urandom_range(7) == 0) img[$urandom_range(15)] = 8'($urandom);
			end else if (pick < 85) begin
				img = '{MRK_PREFIX, MRK_SOI};
				push_random(img, $urandom_range(22, 40));
				if ($urandom_range(1) != 0) img[2] = MRK_PREFIX;
			end else begin
				img.delete();
				push_random(img, $urandom_range(1, 40));
			end
			if ($urandom_range(7) == 0) chop(img, $urandom_range(1, img.size()));
			send_file(img);
			files++;
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);    // room for any stray result word
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
